[src/mailbox_pool_fifo_engine_core_assert.svh]
// ----------------------------------------------------------------------------
// Mailbox pool engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_POOL_FIFO_ENGINE_CORE_ASSERT_SVH
`define MAILBOX_POOL_FIFO_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MPFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MPFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mpfe_pkg.sv]
// ----------------------------------------------------------------------------
// Mailbox pool engine package
// Field widths, request kinds, status codes and controller state codes.
// ----------------------------------------------------------------------------
package mpfe_pkg;

    localparam int WORD_W   = 32;
    localparam int MSG_W    = 3 * WORD_W;
    localparam int KIND_W   = 2;
    localparam int BOX_FW   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_SEND  = 2'd2,
        K_RECV  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_FETCH = 3'b100
    } state_t;

endpackage

[src/mpfe_box_table.sv]
// ----------------------------------------------------------------------------
// Mailbox table
// One entry per mailbox: free-list link, write slot, read slot and fill
// count, in a synchronous memory. Entries never written read as reset values.
// ----------------------------------------------------------------------------
module mpfe_box_table #(
    parameter int NUM_BOXES = 32,
    parameter int BOX_DEPTH = 8
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  rd_en,
    input  logic [$clog2(NUM_BOXES)-1:0]                          rd_addr,
    output logic [$clog2(NUM_BOXES+1)-1:0]                        rd_link,
    output logic [((BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1)-1:0]  rd_wslot,
    output logic [((BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1)-1:0]  rd_rslot,
    output logic [$clog2(BOX_DEPTH+1)-1:0]                        rd_count,
    input  logic                                                  wr_en,
    input  logic [$clog2(NUM_BOXES)-1:0]                          wr_addr,
    input  logic [$clog2(NUM_BOXES+1)-1:0]                        wr_link,
    input  logic [((BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1)-1:0]  wr_wslot,
    input  logic [((BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1)-1:0]  wr_rslot,
    input  logic [$clog2(BOX_DEPTH+1)-1:0]                        wr_count
);

    localparam int BOX_IW = $clog2(NUM_BOXES);
    localparam int LINK_W = $clog2(NUM_BOXES + 1);
    localparam int SLOT_W = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BOX_DEPTH + 1);

    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [SLOT_W-1:0] wslot;
        logic [SLOT_W-1:0] rslot;
        logic [CNT_W-1:0]  count;
    } entry_t;

    entry_t                 mem [NUM_BOXES];
    entry_t                 rd_data_reg;
    logic [BOX_IW-1:0]      rd_addr_reg;
    logic                   rd_valid_reg;
    logic [NUM_BOXES-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{link: wr_link, wslot: wr_wslot, rslot: wr_rslot,
                              count: wr_count};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An unwritten entry holds the reset link to the next lower mailbox.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_link  = rd_data_reg.link;
            rd_wslot = rd_data_reg.wslot;
            rd_rslot = rd_data_reg.rslot;
            rd_count = rd_data_reg.count;
        end
        else
        begin
            rd_link  = (rd_addr_reg == '0) ? LINK_W'(NUM_BOXES)
                                           : LINK_W'(rd_addr_reg) - LINK_W'(1);
            rd_wslot = '0;
            rd_rslot = '0;
            rd_count = '0;
        end
    end

endmodule

[src/mpfe_msg_store.sv]
// ----------------------------------------------------------------------------
// Message store
// Synchronous single-port-write, single-port-read memory of three-word
// messages with a registered read.
// ----------------------------------------------------------------------------
module mpfe_msg_store
    import mpfe_pkg::*;
#(
    parameter int NUM_BOXES = 32,
    parameter int BOX_DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [$clog2(NUM_BOXES*BOX_DEPTH)-1:0]      wr_addr,
    input  logic [MSG_W-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [$clog2(NUM_BOXES*BOX_DEPTH)-1:0]      rd_addr,
    output logic [MSG_W-1:0]                            rd_data
);

    localparam int DEPTH = NUM_BOXES * BOX_DEPTH;

    logic [MSG_W-1:0] mem [DEPTH];
    logic [MSG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/mailbox_pool_fifo_engine_core.sv]
// ----------------------------------------------------------------------------
// Mailbox pool engine: allocate, free, send and receive on a pool of ring FIFOs.
// Allocate, free and send are decided in LOOK; done is strobed from a register;
// a successful receive waits in FETCH for the message words. A new request is
// taken only in IDLE, after the table read and, for receive, the store read.
// Reset: the table reads as its reset image at once; the store is undefined.
// ----------------------------------------------------------------------------
`include "mailbox_pool_fifo_engine_core_assert.svh"

module mailbox_pool_fifo_engine_core
    import mpfe_pkg::*;
#(
    parameter int NUM_BOXES = 32,
    parameter int BOX_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [KIND_W-1:0]           kind,
    input  logic [BOX_FW-1:0]           box,
    input  logic signed [WORD_W-1:0]    result_in,
    input  logic signed [WORD_W-1:0]    move_in,
    input  logic signed [WORD_W-1:0]    explored_in,
    output logic                        done,
    output logic [STATUS_W-1:0]         status,
    output logic [BOX_FW-1:0]           box_given,
    output logic signed [WORD_W-1:0]    result_out,
    output logic signed [WORD_W-1:0]    move_out,
    output logic signed [WORD_W-1:0]    explored_out
);

    localparam int BOX_IW = $clog2(NUM_BOXES);
    localparam int LINK_W = $clog2(NUM_BOXES + 1);
    localparam int SLOT_W = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BOX_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_BOXES * BOX_DEPTH);

    // The controller walks three one-hot states. In IDLE it takes a request
    // and launches the mailbox table read. In LOOK the table entry is back:
    // the request is decided, the table and free-list head are written back,
    // and a send writes its message. A successful receive launches a store
    // read and waits in FETCH for the message words.
    state_t                 state_reg;
    state_t                 state_next;

    // Request captured at acceptance.
    kind_t                  kind_reg;
    logic [BOX_IW-1:0]      box_idx_reg;
    logic                   box_ok_reg;
    logic [MSG_W-1:0]       words_reg;

    // Head of the free list; the value NUM_BOXES marks an empty list.
    logic [LINK_W-1:0]      head_reg;
    logic [LINK_W-1:0]      head_next;
    logic                   head_null;

    // Result registers.
    logic                   done_reg;
    status_t                status_reg;
    logic [BOX_FW-1:0]      given_reg;
    logic [MSG_W-1:0]       msg_out_reg;

    logic                   accept;
    logic                   finish;
    status_t                look_status;
    logic [BOX_FW-1:0]      look_given;

    // Mailbox table port signals.
    logic                   tbl_rd_en;
    logic [BOX_IW-1:0]      tbl_rd_addr;
    logic [LINK_W-1:0]      tbl_link;
    logic [SLOT_W-1:0]      tbl_wslot;
    logic [SLOT_W-1:0]      tbl_rslot;
    logic [CNT_W-1:0]       tbl_count;
    logic                   tbl_wr_en;
    logic [LINK_W-1:0]      tbl_wr_link;
    logic [SLOT_W-1:0]      tbl_wr_wslot;
    logic [SLOT_W-1:0]      tbl_wr_rslot;
    logic [CNT_W-1:0]       tbl_wr_count;

    // Message store port signals.
    logic                   st_wr_en;
    logic                   st_rd_en;
    logic [ADDR_W-1:0]      st_wr_addr;
    logic [ADDR_W-1:0]      st_rd_addr;
    logic [MSG_W-1:0]       st_rd_data;
    logic [ADDR_W-1:0]      box_base;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign head_null = (head_reg >= LINK_W'(NUM_BOXES));

    // An allocate reads the entry at the free-list head to find its
    // successor; every other request reads the addressed mailbox.
    assign tbl_rd_en   = accept;
    assign tbl_rd_addr = (kind_t'(kind) == K_ALLOC) ? head_reg[BOX_IW-1:0]
                                                    : BOX_IW'(box);

    // Each mailbox owns BOX_DEPTH consecutive store entries.
    assign box_base   = ADDR_W'(box_idx_reg) * ADDR_W'(BOX_DEPTH);
    assign st_wr_addr = box_base + ADDR_W'(tbl_wslot);
    assign st_rd_addr = box_base + ADDR_W'(tbl_rslot);

    mpfe_box_table #(
        .NUM_BOXES (NUM_BOXES),
        .BOX_DEPTH (BOX_DEPTH)
    ) u_box_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_link  (tbl_link),
        .rd_wslot (tbl_wslot),
        .rd_rslot (tbl_rslot),
        .rd_count (tbl_count),
        .wr_en    (tbl_wr_en),
        .wr_addr  (box_idx_reg),
        .wr_link  (tbl_wr_link),
        .wr_wslot (tbl_wr_wslot),
        .wr_rslot (tbl_wr_rslot),
        .wr_count (tbl_wr_count)
    );

    mpfe_msg_store #(
        .NUM_BOXES (NUM_BOXES),
        .BOX_DEPTH (BOX_DEPTH)
    ) u_msg_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (words_reg),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Decision logic. Every refused request leaves the table, the head and
    // the store untouched and only reports its status.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tbl_wr_en    = 1'b0;
        tbl_wr_link  = tbl_link;
        tbl_wr_wslot = tbl_wslot;
        tbl_wr_rslot = tbl_rslot;
        tbl_wr_count = tbl_count;
        st_wr_en     = 1'b0;
        st_rd_en     = 1'b0;
        look_status  = ST_OK;
        look_given   = '0;
        finish       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                finish     = 1'b1;
                state_next = S_IDLE;
                unique case (kind_reg)
                    K_ALLOC:
                    begin
                        if (head_null)
                        begin
                            look_status = ST_NO_FREE;
                        end
                        else
                        begin
                            look_given = BOX_FW'(head_reg);
                            head_next  = tbl_link;
                        end
                    end
                    K_FREE:
                    begin
                        // A box already on the list is pushed again unchecked.
                        if (box_ok_reg)
                        begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_link = head_reg;
                            head_next   = LINK_W'(box_idx_reg);
                        end
                    end
                    K_SEND:
                    begin
                        if (!box_ok_reg || tbl_count >= CNT_W'(BOX_DEPTH))
                        begin
                            look_status = ST_FULL;
                        end
                        else
                        begin
                            st_wr_en     = 1'b1;
                            tbl_wr_en    = 1'b1;
                            tbl_wr_wslot = (tbl_wslot == SLOT_W'(BOX_DEPTH - 1))
                                           ? '0 : tbl_wslot + SLOT_W'(1);
                            tbl_wr_count = tbl_count + CNT_W'(1);
                        end
                    end
                    K_RECV:
                    begin
                        if (!box_ok_reg || tbl_count == '0)
                        begin
                            look_status = ST_EMPTY;
                        end
                        else
                        begin
                            finish       = 1'b0;
                            state_next   = S_FETCH;
                            st_rd_en     = 1'b1;
                            tbl_wr_en    = 1'b1;
                            tbl_wr_rslot = (tbl_rslot == SLOT_W'(BOX_DEPTH - 1))
                                           ? '0 : tbl_rslot + SLOT_W'(1);
                            tbl_wr_count = tbl_count - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        look_status = ST_OK;
                    end
                endcase
            end
            S_FETCH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LINK_W'(NUM_BOXES - 1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= finish || (state_reg == S_FETCH);
        end
    end

    // Request capture. A box number beyond the pool is flagged here once.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind_t'(kind);
            box_idx_reg <= BOX_IW'(box);
            box_ok_reg  <= (32'(box) < 32'(NUM_BOXES));
            words_reg   <= {explored_in, move_in, result_in};
        end
    end

    // Result payload. Message words stay zero unless a receive succeeds.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg  <= look_status;
            given_reg   <= look_given;
            msg_out_reg <= '0;
        end
        else if (state_reg == S_FETCH)
        begin
            status_reg  <= ST_OK;
            given_reg   <= '0;
            msg_out_reg <= st_rd_data;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign box_given    = given_reg;
    assign result_out   = msg_out_reg[WORD_W-1:0];
    assign move_out     = msg_out_reg[2*WORD_W-1:WORD_W];
    assign explored_out = msg_out_reg[3*WORD_W-1:2*WORD_W];

    // An accepted request always moves the controller into the lookup.
    `MPFE_ASSERT_NEXT(a_accept_to_look, accept, state_reg == S_LOOK,
                      "accepted request did not enter lookup")
    // A result is only presented once the controller is back in idle.
    `MPFE_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE,
                     "result strobe while a request is in progress")
    // A refused request never carries message words.
    `MPFE_ASSERT_NOW(a_refusal_clean, done_reg && status_reg != ST_OK,
                     msg_out_reg == '0 && given_reg == '0,
                     "refused request returned data")
    // Table and store writes happen only while a request is being decided.
    `MPFE_ASSERT_NOW(a_write_in_look, tbl_wr_en || st_wr_en, state_reg == S_LOOK,
                     "memory write outside lookup")

endmodule
